// File: src/conv3x3_fixed_kernel_stream_top_macros.svh
// assertion macros shared by the 3x3 convolution stream rtl
`ifndef CONV3X3_FIXED_KERNEL_STREAM_TOP_MACROS_SVH
`define CONV3X3_FIXED_KERNEL_STREAM_TOP_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define CV3KS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cv3ks: property violated");
// condition must never be seen at a clock edge outside reset
`define CV3KS_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("cv3ks: forbidden condition seen");
`else
`define CV3KS_ASSERT(lbl, clk, rst_n, prop)
`define CV3KS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: src/cv3ks_pkg.sv
// types, constants and weight function of the 3x3 convolution stream
package cv3ks_pkg;

  // image geometry
  localparam int MaxWidth = 64;
  localparam int MinWidth = 3;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int LwW      = 7;
  localparam int LwReset  = 64;
  localparam int CmpW     = (ColW + 1 > LwW) ? ColW + 1 : LwW;

  // row counter saturates once two rows are buffered
  localparam int RowCntW = 2;
  localparam int RowFull = 2;

  // kernel
  localparam int PixW          = 8;
  localparam int Taps          = 3;
  localparam int TapW          = 2;
  localparam int WeightBase    = 11;
  localparam int WeightColStep = 3;

  // output queue
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = FifoPtrW + 1;
  localparam int CreditW   = FifoCntW + 1;

  typedef logic [PixW-1:0] pix_t;

  // one window column: index 0 oldest row, index Taps-1 current row
  typedef pix_t [Taps-1:0] pix_col_t;

  // line store word: two rows above the current one at one column
  typedef struct packed {
    pix_t top;
    pix_t mid;
  } line_word_t;

  typedef struct packed {
    pix_t pixel_out;
    logic row_last;
  } res_t;

  // kernel weight for column offset tap and row offset row
  function automatic pix_t tap_weight(logic [TapW-1:0] tap, logic [TapW-1:0] row);
    return PixW'(WeightBase + WeightColStep * int'(tap) + int'(row));
  endfunction

endpackage

// File: src/cv3ks_if.sv
// valid/ready channel interfaces of the 3x3 convolution stream

// input pixel channel
interface cv3ks_pix_if;
  import cv3ks_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_in;
  logic            frame_start;
  modport source (output valid, pixel_in, frame_start, input ready);
  modport sink (input valid, pixel_in, frame_start, output ready);
endinterface

// result channel
interface cv3ks_res_if;
  import cv3ks_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_out;
  logic            row_last;
  modport source (output valid, pixel_out, row_last, input ready);
  modport sink (input valid, pixel_out, row_last, output ready);
endinterface

// line width register write channel
interface cv3ks_cfg_if;
  import cv3ks_pkg::*;
  logic           valid;
  logic           ready;
  logic [LwW-1:0] line_width;
  modport source (output valid, line_width, input ready);
  modport sink (input valid, line_width, output ready);
endinterface

// File: src/cv3ks_line_mem.sv
// line store memory: two previous rows per column, registered read
module cv3ks_line_mem (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [cv3ks_pkg::ColW-1:0] rd_addr_i,
  output cv3ks_pkg::line_word_t  rd_data_o,
  input  logic                   wr_en_i,
  input  logic [cv3ks_pkg::ColW-1:0] wr_addr_i,
  input  cv3ks_pkg::line_word_t  wr_data_i
);
  import cv3ks_pkg::*;

  line_word_t mem_q [MaxWidth];
  line_word_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/cv3ks_cell.sv
// one window column cell: adds its weighted column to the partial sum
module cv3ks_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [cv3ks_pkg::TapW-1:0] tap_i,
  input  cv3ks_pkg::pix_col_t        col_i,
  input  cv3ks_pkg::pix_t            psum_i,
  output cv3ks_pkg::pix_t            psum_o
);
  import cv3ks_pkg::*;

  pix_t psum_d;
  pix_t psum_q;

  // weighted column sum, modulo 256
  always_comb begin
    psum_d = psum_i;
    for (int j = 0; j < Taps; j++) begin
      psum_d = psum_d + pix_t'(col_i[j] * tap_weight(tap_i, TapW'(j)));
    end
  end

  // partial sum handed to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psum_q <= '0;
    end else if (en_i) begin
      psum_q <= psum_d;
    end
  end

  assign psum_o = psum_q;

endmodule

// File: src/cv3ks_fifo.sv
// small result queue between the cell chain and the output channel
module cv3ks_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  cv3ks_pkg::res_t                data_i,
  input  logic                           pop_i,
  output logic                           valid_o,
  output cv3ks_pkg::res_t                data_o,
  output logic [cv3ks_pkg::FifoCntW-1:0] count_o
);
  import cv3ks_pkg::*;

  res_t                slot_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

// File: src/conv3x3_fixed_kernel_stream_top.sv
// top level of the streaming 3x3 convolution with two line buffers
// a result passes stage 1, the cell sums of stage 2 and the result queue before its transfer
// throughput: one pixel per clock when credit allows, one line store read and write per pixel
// a 4-entry result queue lets pixels keep flowing while a result waits on the output
// reset: counters clear, line width returns to 64, window sums clear
// reset leaves the line store as it is; there is no clearing pass
`include "conv3x3_fixed_kernel_stream_top_macros.svh"

module conv3x3_fixed_kernel_stream_top (
  input logic        clk_i,
  input logic        rst_ni,
  cv3ks_pix_if.sink   pix_i,
  cv3ks_res_if.source res_o,
  cv3ks_cfg_if.sink   cfg_i
);
  import cv3ks_pkg::*;

  // configuration and position state
  logic [LwW-1:0]     line_width_q;
  logic [ColW-1:0]    col_q, col_d;
  logic [RowCntW-1:0] row_q, row_d;

  // stage 0 decode
  logic               accept;
  logic [ColW-1:0]    cur_col;
  logic [RowCntW-1:0] cur_row;
  logic [CmpW-1:0]    lw_ext;
  logic [CmpW-1:0]    w_eff;
  logic [CmpW-1:0]    col_inc;
  logic               last;
  logic               win;

  // stage 1
  logic               s1_valid_q;
  logic               s1_win_q;
  logic               s1_last_q;
  logic [ColW-1:0]    s1_col_q;
  pix_t               s1_px_q;
  line_word_t         rd_word;
  line_word_t         line_word;
  line_word_t         wr_word;
  pix_col_t           fresh_col;

  // forward path for a write that meets a read of the same column
  logic               fwd_v_q;
  logic [ColW-1:0]    fwd_addr_q;
  line_word_t         fwd_word_q;

  // stage 2
  logic               s2_valid_q;
  logic               s2_emit_q;
  logic               s2_last_q;

  // cell chain partial sums
  pix_t               psum [Taps+1];

  // output queue
  logic               fifo_push;
  res_t               fifo_din;
  logic               fifo_pop;
  logic               fifo_valid;
  res_t               fifo_dout;
  logic [FifoCntW-1:0] fifo_count;
  logic [CreditW-1:0] credit_used;

  // line width register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LwW'(LwReset);
    end else if (cfg_i.valid && cfg_i.ready) begin
      line_width_q <= cfg_i.line_width;
    end
  end

  // input flow control counts every item still in the chain
  assign credit_used = CreditW'(fifo_count) + CreditW'(s1_valid_q) + CreditW'(s2_valid_q);
  assign pix_i.ready = (credit_used < CreditW'(FifoDepth));
  assign accept      = pix_i.valid && pix_i.ready;

  // column and row tracking
  always_comb begin
    cur_col = pix_i.frame_start ? '0 : col_q;
    cur_row = pix_i.frame_start ? '0 : row_q;
    lw_ext  = CmpW'(line_width_q);
    if (lw_ext < CmpW'(MinWidth)) begin
      w_eff = CmpW'(MinWidth);
    end else if (lw_ext > CmpW'(MaxWidth)) begin
      w_eff = CmpW'(MaxWidth);
    end else begin
      w_eff = lw_ext;
    end
    col_inc = CmpW'(cur_col) + 1'b1;
    last    = (col_inc >= w_eff);
    win     = (cur_row == RowCntW'(RowFull)) && (cur_col >= ColW'(Taps - 1));
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      col_d = last ? '0 : ColW'(col_inc);
      row_d = (last && (cur_row != RowCntW'(RowFull))) ? cur_row + 1'b1 : cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line store, read at transfer and written back in the cycle after
  cv3ks_line_mem u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (cur_col),
    .rd_data_o (rd_word),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_word)
  );

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_v_q    <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      fwd_v_q    <= s1_valid_q && accept;
    end
  end

  // stage 1 payload and forward data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_win_q  <= win;
      s1_last_q <= last;
      s1_col_q  <= cur_col;
      s1_px_q   <= pix_i.pixel_in;
    end
    fwd_addr_q <= s1_col_q;
    fwd_word_q <= wr_word;
  end

  // fresh column and line store update
  always_comb begin
    line_word = (fwd_v_q && (fwd_addr_q == s1_col_q)) ? fwd_word_q : rd_word;
    wr_word.top = line_word.mid;
    wr_word.mid = s1_px_q;
    fresh_col[0] = line_word.top;
    fresh_col[1] = line_word.mid;
    fresh_col[2] = s1_px_q;
  end

  // chain of column cells, oldest column first
  assign psum[0] = '0;

  for (genvar g = 0; g < Taps; g++) begin : g_cell
    cv3ks_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (s1_valid_q),
      .tap_i  (TapW'(g)),
      .col_i  (fresh_col),
      .psum_i (psum[g]),
      .psum_o (psum[g+1])
    );
  end

  // stage 2 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_emit_q  <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
      s2_emit_q  <= s1_valid_q && s1_win_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_last_q <= s1_last_q;
    end
  end

  // result queue and output channel
  assign fifo_push          = s2_valid_q && s2_emit_q;
  assign fifo_din.pixel_out = psum[Taps];
  assign fifo_din.row_last  = s2_last_q;
  assign fifo_pop           = res_o.valid && res_o.ready;

  cv3ks_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (fifo_din),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_dout),
    .count_o (fifo_count)
  );

  assign res_o.valid     = fifo_valid;
  assign res_o.pixel_out = fifo_dout.pixel_out;
  assign res_o.row_last  = fifo_dout.row_last;

  // checks
  `CV3KS_NEVER(a_fifo_no_overflow, clk_i, rst_ni, fifo_push && (fifo_count == FifoCntW'(FifoDepth)))
  `CV3KS_NEVER(a_credit_bound, clk_i, rst_ni, credit_used > CreditW'(FifoDepth))
  `CV3KS_ASSERT(a_fwd_needs_s1, clk_i, rst_ni, fwd_v_q |-> s1_valid_q)
  `CV3KS_ASSERT(a_emit_after_window, clk_i, rst_ni, s2_emit_q |-> $past(s1_win_q))

endmodule
